// ===== rtl/spsf_pkg.sv =====
package spsf_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_INTERACT = 2'd1,
    CMD_READ     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_LOAD_WR,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_FORCE_RD,
    ST_FORCE_WAIT,
    ST_FORCE_WR,
    ST_DONE
  } state_t;

  // what the shared multiplier is working on
  typedef enum logic [2:0] {
    OP_INTERP1,
    OP_INTERP2,
    OP_SQUARE,
    OP_TENSION,
    OP_ENERGY,
    OP_FORCE,
    OP_SHARE
  } mul_op_t;

  // root unit modes
  typedef enum logic {
    ROOT_SQRT,
    ROOT_DIV
  } root_mode_t;

  // field widths
  localparam int BEAD_IN_W = 10;
  localparam int COORD_W   = 32;
  localparam int FORCE_W   = 48;
  localparam int ENERGY_W  = 48;

  // shared multiplier: a times b, b taken one digit per cycle
  localparam int MUL_A_W   = 50;
  localparam int MUL_B_W   = 34;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_DIGIT = 8;
  localparam int MUL_STEPS = (MUL_B_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // root / divide unit
  localparam int RAD_W      = 66;
  localparam int DIST_W     = 33;
  localparam int UNIT_SHIFT = 30;
  localparam int ROOT_CNT_W = 6;

endpackage

// ===== rtl/spsf_ram.sv =====
module spsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spsf_mul.sv =====
module spsf_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spsf_pkg::MUL_A_W-1:0] a,
  input  logic [spsf_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [spsf_pkg::MUL_P_W-1:0] p
);
  import spsf_pkg::*;

  logic [MUL_P_W-1:0]   acc;
  logic [MUL_P_W-1:0]   ash;
  logic [MUL_B_W-1:0]   bsh;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 run;
  logic [MUL_P_W-1:0]   partial;

  // one digit of b against the shifted a
  assign partial = ash * MUL_P_W'(bsh[MUL_DIGIT-1:0]);
  assign p = acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-and-add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= MUL_P_W'(a);
      bsh <= b;
    end else if (run) begin
      acc <= acc + partial;
      ash <= ash << MUL_DIGIT;
      bsh <= bsh >> MUL_DIGIT;
    end
  end

endmodule

// ===== rtl/spsf_root.sv =====
module spsf_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  spsf_pkg::root_mode_t          mode,
  input  logic [spsf_pkg::RAD_W-1:0]    rad,
  input  logic [spsf_pkg::DIST_W-1:0]   den,
  output logic                          done,
  output logic [spsf_pkg::DIST_W-1:0]   res
);
  import spsf_pkg::*;

  logic [RAD_W-1:0]      acc;
  logic [RAD_W-1:0]      trial;
  logic [RAD_W-1:0]      bitv;
  logic [DIST_W-1:0]     quo;
  logic [ROOT_CNT_W-1:0] cnt;
  logic                  run;
  root_mode_t            mode_r;
  logic [RAD_W-1:0]      sub_b;
  logic [RAD_W:0]        diff;
  logic                  ge;

  // shared compare and subtract
  assign sub_b = (mode_r == ROOT_SQRT) ? trial + bitv : trial;
  assign diff  = {1'b0, acc} - {1'b0, sub_b};
  assign ge    = ~diff[RAD_W];
  assign res   = (mode_r == ROOT_SQRT) ? trial[DIST_W-1:0] : quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= (mode == ROOT_SQRT) ? ROOT_CNT_W'(DIST_W) : ROOT_CNT_W'(UNIT_SHIFT + 1);
      end else if (run) begin
        cnt <= cnt - ROOT_CNT_W'(1);
        if (cnt == ROOT_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      acc    <= rad;
      quo    <= '0;
      if (mode == ROOT_SQRT) begin
        trial <= '0;
        bitv  <= RAD_W'(1) << (2 * (DIST_W - 1));
      end else begin
        trial <= RAD_W'(den) << UNIT_SHIFT;
        bitv  <= '0;
      end
    end else if (run) begin
      if (ge) begin
        acc <= diff[RAD_W-1:0];
      end
      if (mode_r == ROOT_SQRT) begin
        trial <= ge ? (trial >> 1) + bitv : trial >> 1;
        bitv  <= bitv >> 2;
      end else begin
        trial <= trial >> 1;
        quo   <= {quo[DIST_W-2:0], ge};
      end
    end
  end

endmodule

// ===== rtl/segment_point_spring_force.sv =====
// Harmonic spring between interpolated points on two bead pairs, Q16.16 fixed
// point. Beads are loaded (command 0), interactions add forces to four beads
// (command 1), a read returns and clears one bead's force (command 2), and
// command 3 clears the energy total and the invalid flag. Every transaction
// gives one result transaction. After reset the block zeroes its force memory
// before in_ready rises. The time an interaction takes is set by the shared
// multiplier (26 products, 8 bits of the multiplier per cycle) and by the
// shift-subtract unit that forms the square root and three divides one bit
// per cycle. An index at or beyond BEAD_COUNT is wrapped by subtracting
// BEAD_COUNT until it is in range, before the command goes on. in_ready is
// high only while the block is idle; a finished result waits in the output
// register.
module segment_point_spring_force #(
  parameter int BEAD_COUNT    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic [9:0]                 bead_a,
  input  logic [9:0]                 bead_b,
  input  logic [9:0]                 bead_c,
  input  logic [9:0]                 bead_d,
  input  logic signed [31:0]         coord_x,
  input  logic signed [31:0]         coord_y,
  input  logic signed [31:0]         coord_z,
  input  logic [31:0]                stiffness,
  input  logic [31:0]                rest_length,
  input  logic [FRACTION_BITS:0]     first_fraction,
  input  logic [FRACTION_BITS:0]     second_fraction,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [47:0]                energy_term,
  output logic [47:0]                energy_total,
  output logic signed [47:0]         tension,
  output logic                       invalid,
  output logic signed [47:0]         force_x,
  output logic signed [47:0]         force_y,
  output logic signed [47:0]         force_z
);
  import spsf_pkg::*;

  localparam int AW  = $clog2(BEAD_COUNT);
  localparam int IW  = (AW > BEAD_IN_W) ? AW : BEAD_IN_W;
  localparam int FW  = FRACTION_BITS + 1;
  localparam int CW3 = 3 * COORD_W;
  localparam int FW3 = 3 * FORCE_W;
  localparam logic [FW-1:0] ONE_FR = FW'(1) << FRACTION_BITS;

  state_t state, state_next;

  cmd_t             cmd_r;
  logic [IW-1:0]    bead_a_r, bead_b_r, bead_c_r, bead_d_r;
  logic [31:0]      kst_r, rest_r;
  logic [FW-1:0]    f1_r, f2_r;
  logic [CW3-1:0]   cw_a, cw_b, cw_c, cw_d;
  logic [31:0]      p1_r;
  logic [3*DIST_W-1:0] mag_q;
  logic [2:0]       dneg_q;
  logic [RAD_W-1:0] s_acc;
  logic [DIST_W-1:0] dist_r;
  logic [49:0]      t_r;
  logic [30:0]      u_r;
  logic [FW3-1:0]   g_q;
  logic [2:0]       gneg_q;
  logic [FW3-1:0]   frc;
  logic [47:0]      e_r, ten_r;
  logic [47:0]      energy_sum;
  logic             error_seen;
  logic [AW-1:0]    clr_cnt;
  logic [1:0]       i_r, k_r;
  mul_op_t          op_r;
  root_mode_t       rmode_r;

  logic             in_acc, out_free;
  logic             wrap_busy;
  logic [IW-1:0]    bead_sel;
  logic             mul_start, mul_done, root_start, root_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIST_W-1:0]  root_res;
  logic [RAD_W-1:0]   root_rad;
  logic             coord_we, coord_re, force_we, force_re;
  logic [CW3-1:0]   coord_rdata;
  logic [FW3-1:0]   force_rdata, force_wdata;
  logic [AW-1:0]    force_waddr;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // index wrap check
  assign wrap_busy = (32'(bead_a_r) >= 32'(BEAD_COUNT)) || (32'(bead_b_r) >= 32'(BEAD_COUNT)) ||
                     (32'(bead_c_r) >= 32'(BEAD_COUNT)) || (32'(bead_d_r) >= 32'(BEAD_COUNT));

  always_comb begin
    case (i_r)
      2'd0:    bead_sel = bead_a_r;
      2'd1:    bead_sel = bead_b_r;
      2'd2:    bead_sel = bead_c_r;
      default: bead_sel = bead_d_r;
    endcase
  end

  // interpolation along the current pair, current axis in the low word
  logic signed [31:0] ip_lo, ip_hi;
  logic [FW-1:0]      ip_f;
  logic signed [32:0] ip_diff;
  logic               ip_neg;
  logic [32:0]        ip_mag;
  logic [MUL_P_W-1:0] ip_round;
  logic [33:0]        ip_qmag;
  logic signed [34:0] ip_q, ip_pt;
  logic signed [32:0] d_c;
  logic               d_neg;
  logic [32:0]        d_mag;

  assign ip_lo    = (op_r == OP_INTERP1) ? cw_a[31:0] : cw_c[31:0];
  assign ip_hi    = (op_r == OP_INTERP1) ? cw_b[31:0] : cw_d[31:0];
  assign ip_f     = (op_r == OP_INTERP1) ? f1_r : f2_r;
  assign ip_diff  = {ip_hi[31], ip_hi} - {ip_lo[31], ip_lo};
  assign ip_neg   = ip_diff[32];
  assign ip_mag   = ip_neg ? 33'(-ip_diff) : 33'(ip_diff);
  assign ip_round = mul_p + (ip_neg ? MUL_P_W'(ONE_FR - FW'(1)) : MUL_P_W'(0));
  assign ip_qmag  = ip_round[FRACTION_BITS +: 34];
  assign ip_q     = ip_neg ? -$signed({1'b0, ip_qmag}) : $signed({1'b0, ip_qmag});
  assign ip_pt    = $signed({{3{ip_lo[31]}}, ip_lo}) + ip_q;
  assign d_c      = $signed({p1_r[31], p1_r}) - $signed({ip_pt[31], ip_pt[31:0]});
  assign d_neg    = d_c[32];
  assign d_mag    = d_neg ? 33'(-d_c) : 33'(d_c);

  // stretch, tension and energy
  logic signed [34:0] s_c;
  logic               s_neg;
  logic [33:0]        as_c;
  logic [47:0]        tsat_c, ten_c;
  logic [66:0]        e_full;
  logic               e_ovf;
  logic [47:0]        e_val;
  logic [48:0]        esum;

  assign s_c    = $signed({2'b0, dist_r}) - $signed({3'b0, rest_r});
  assign s_neg  = s_c[34];
  assign as_c   = s_neg ? 34'(-s_c) : 34'(s_c);
  always_comb begin
    if (s_neg) begin
      tsat_c = (t_r > 50'h0_8000_0000_0000) ? 48'h8000_0000_0000 : t_r[47:0];
    end else begin
      tsat_c = (t_r > 50'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : t_r[47:0];
    end
  end
  assign ten_c  = s_neg ? -tsat_c : tsat_c;
  assign e_full = mul_p[MUL_P_W-1:17];
  assign e_ovf  = |e_full[66:48];
  assign e_val  = e_ovf ? '1 : e_full[47:0];
  assign esum   = {1'b0, energy_sum} + {1'b0, e_val};

  // force share for the current bead and axis
  logic [FW-1:0]      w_sel;
  logic [47:0]        m_c;
  logic               sh_neg;
  logic signed [48:0] fsum;
  logic [47:0]        fnew;

  always_comb begin
    case (i_r)
      2'd0:    w_sel = ONE_FR - f1_r;
      2'd1:    w_sel = f1_r;
      2'd2:    w_sel = ONE_FR - f2_r;
      default: w_sel = f2_r;
    endcase
  end
  assign m_c    = mul_p[FRACTION_BITS +: 48];
  assign sh_neg = i_r[1] ? gneg_q[0] : !gneg_q[0];
  assign fsum   = $signed({frc[47], frc[47:0]}) +
                  (sh_neg ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c}));
  always_comb begin
    case (fsum[48:47])
      2'b01:   fnew = 48'h7FFF_FFFF_FFFF;
      2'b10:   fnew = 48'h8000_0000_0000;
      default: fnew = fsum[47:0];
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (op_r)
      OP_INTERP1, OP_INTERP2: begin
        mul_a = MUL_A_W'(ip_mag);
        mul_b = MUL_B_W'(ip_f);
      end
      OP_SQUARE: begin
        mul_a = MUL_A_W'(mag_q[3*DIST_W-1 -: DIST_W]);
        mul_b = MUL_B_W'(mag_q[3*DIST_W-1 -: DIST_W]);
      end
      OP_TENSION: begin
        mul_a = MUL_A_W'(kst_r);
        mul_b = as_c;
      end
      OP_ENERGY: begin
        mul_a = t_r;
        mul_b = as_c;
      end
      OP_FORCE: begin
        mul_a = MUL_A_W'(tsat_c);
        mul_b = MUL_B_W'(u_r);
      end
      default: begin
        mul_a = MUL_A_W'(g_q[47:0]);
        mul_b = MUL_B_W'(w_sel);
      end
    endcase
  end

  assign root_rad = (rmode_r == ROOT_SQRT) ? s_acc
                                           : RAD_W'({mag_q[DIST_W-1:0], 30'b0});

  spsf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  spsf_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .mode  (rmode_r),
    .rad   (root_rad),
    .den   (dist_r),
    .done  (root_done),
    .res   (root_res)
  );

  spsf_ram #(.WIDTH(CW3), .DEPTH(BEAD_COUNT)) u_coord_ram (
    .clk   (clk),
    .we    (coord_we),
    .waddr (bead_sel[AW-1:0]),
    .wdata (cw_a),
    .re    (coord_re),
    .raddr (bead_sel[AW-1:0]),
    .rdata (coord_rdata)
  );

  assign force_waddr = (state == ST_CLEAR) ? clr_cnt : bead_sel[AW-1:0];
  assign force_wdata = ((state == ST_CLEAR) || (cmd_r == CMD_READ)) ? '0 : frc;

  spsf_ram #(.WIDTH(FW3), .DEPTH(BEAD_COUNT)) u_force_ram (
    .clk   (clk),
    .we    (force_we),
    .waddr (force_waddr),
    .wdata (force_wdata),
    .re    (force_re),
    .raddr (bead_sel[AW-1:0]),
    .rdata (force_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(BEAD_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_WRAP;
      end
      ST_WRAP: begin
        if (!wrap_busy) begin
          case (cmd_r)
            CMD_LOAD:     state_next = ST_LOAD_WR;
            CMD_INTERACT: state_next = ST_FETCH;
            CMD_READ:     state_next = ST_FORCE_RD;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_LOAD_WR: state_next = ST_DONE;
      ST_FETCH:   state_next = ST_FETCH_WAIT;
      ST_FETCH_WAIT: begin
        state_next = (i_r == 2'd3) ? ST_MUL : ST_FETCH;
      end
      ST_MUL: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_SQUARE: state_next = (k_r == 2'd2) ? ST_ROOT : ST_MUL;
            OP_ENERGY: state_next = (dist_r == '0) ? ST_DONE : ST_ROOT;
            OP_FORCE:  state_next = (k_r == 2'd2) ? ST_FORCE_RD : ST_ROOT;
            OP_SHARE:  state_next = (k_r == 2'd2) ? ST_FORCE_WR : ST_MUL;
            default:   state_next = ST_MUL;
          endcase
        end
      end
      ST_ROOT: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (root_done) state_next = ST_MUL;
      end
      ST_FORCE_RD: state_next = ST_FORCE_WAIT;
      ST_FORCE_WAIT: begin
        state_next = (cmd_r == CMD_READ) ? ST_FORCE_WR : ST_MUL;
      end
      ST_FORCE_WR: begin
        state_next = ((cmd_r == CMD_READ) || (i_r == 2'd3)) ? ST_DONE : ST_FORCE_RD;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    mul_start  = (state == ST_MUL);
    root_start = (state == ST_ROOT);
    coord_we   = (state == ST_LOAD_WR);
    coord_re   = (state == ST_FETCH);
    force_re   = (state == ST_FORCE_RD);
    force_we   = (state == ST_CLEAR) || (state == ST_FORCE_WR);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
      energy_sum <= '0;
      error_seen <= 1'b0;
      i_r        <= '0;
      k_r        <= '0;
      op_r       <= OP_INTERP1;
      rmode_r    <= ROOT_SQRT;
    end else begin
      state <= state_next;
      // result handshake
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        ST_IDLE: begin
          if (in_acc) begin
            i_r  <= '0;
            k_r  <= '0;
            op_r <= OP_INTERP1;
          end
        end
        ST_WRAP: begin
          if (cmd_r == CMD_CLEAR) begin
            energy_sum <= '0;
            error_seen <= 1'b0;
          end
        end
        ST_FETCH_WAIT: i_r <= i_r + 2'd1;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (op_r)
              OP_INTERP1: op_r <= OP_INTERP2;
              OP_INTERP2: op_r <= OP_SQUARE;
              OP_SQUARE: begin
                if (k_r == 2'd2) begin
                  k_r     <= '0;
                  rmode_r <= ROOT_SQRT;
                end else begin
                  k_r  <= k_r + 2'd1;
                  op_r <= OP_INTERP1;
                end
              end
              OP_TENSION: op_r <= OP_ENERGY;
              OP_ENERGY: begin
                energy_sum <= esum[48] ? '1 : esum[47:0];
                if (e_ovf || (dist_r == '0)) error_seen <= 1'b1;
                op_r    <= OP_FORCE;
                rmode_r <= ROOT_DIV;
                k_r     <= '0;
              end
              OP_FORCE: begin
                if (k_r == 2'd2) begin
                  k_r  <= '0;
                  i_r  <= '0;
                  op_r <= OP_SHARE;
                end else begin
                  k_r <= k_r + 2'd1;
                end
              end
              default: begin
                k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
              end
            endcase
          end
        end
        ST_ROOT_WAIT: begin
          if (root_done && (rmode_r == ROOT_SQRT)) op_r <= OP_TENSION;
        end
        ST_FORCE_WR: i_r <= i_r + 2'd1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_r    <= cmd_t'(command);
          bead_a_r <= IW'(bead_a);
          bead_b_r <= IW'(bead_b);
          bead_c_r <= IW'(bead_c);
          bead_d_r <= IW'(bead_d);
          kst_r    <= stiffness;
          rest_r   <= rest_length;
          f1_r     <= (first_fraction > ONE_FR) ? ONE_FR : first_fraction;
          f2_r     <= (second_fraction > ONE_FR) ? ONE_FR : second_fraction;
          cw_a     <= {coord_z, coord_y, coord_x};
          s_acc    <= '0;
          e_r      <= '0;
          ten_r    <= '0;
        end
      end
      ST_WRAP: begin
        if (32'(bead_a_r) >= 32'(BEAD_COUNT)) bead_a_r <= bead_a_r - IW'(BEAD_COUNT);
        if (32'(bead_b_r) >= 32'(BEAD_COUNT)) bead_b_r <= bead_b_r - IW'(BEAD_COUNT);
        if (32'(bead_c_r) >= 32'(BEAD_COUNT)) bead_c_r <= bead_c_r - IW'(BEAD_COUNT);
        if (32'(bead_d_r) >= 32'(BEAD_COUNT)) bead_d_r <= bead_d_r - IW'(BEAD_COUNT);
      end
      ST_FETCH_WAIT: begin
        case (i_r)
          2'd0:    cw_a <= coord_rdata;
          2'd1:    cw_b <= coord_rdata;
          2'd2:    cw_c <= coord_rdata;
          default: cw_d <= coord_rdata;
        endcase
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_INTERP1: p1_r <= ip_pt[31:0];
            OP_INTERP2: begin
              mag_q  <= {d_mag, mag_q[3*DIST_W-1:DIST_W]};
              dneg_q <= {d_neg, dneg_q[2:1]};
              // bring the next axis into the low word
              cw_a   <= {cw_a[31:0], cw_a[CW3-1:32]};
              cw_b   <= {cw_b[31:0], cw_b[CW3-1:32]};
              cw_c   <= {cw_c[31:0], cw_c[CW3-1:32]};
              cw_d   <= {cw_d[31:0], cw_d[CW3-1:32]};
            end
            OP_SQUARE:  s_acc <= s_acc + mul_p[RAD_W-1:0];
            OP_TENSION: t_r <= mul_p[16 +: 50];
            OP_ENERGY: begin
              e_r   <= e_val;
              ten_r <= ten_c;
            end
            OP_FORCE: begin
              g_q    <= {mul_p[UNIT_SHIFT +: 48], g_q[FW3-1:48]};
              gneg_q <= {s_neg ^ dneg_q[0], gneg_q[2:1]};
              mag_q  <= {mag_q[DIST_W-1:0], mag_q[3*DIST_W-1:DIST_W]};
              dneg_q <= {dneg_q[0], dneg_q[2:1]};
            end
            default: begin
              frc    <= {fnew, frc[FW3-1:48]};
              g_q    <= {g_q[47:0], g_q[FW3-1:48]};
              gneg_q <= {gneg_q[0], gneg_q[2:1]};
            end
          endcase
        end
      end
      ST_ROOT_WAIT: begin
        if (root_done) begin
          if (rmode_r == ROOT_SQRT) dist_r <= root_res;
          else u_r <= root_res[30:0];
        end
      end
      ST_FORCE_WAIT: frc <= force_rdata;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      energy_term  <= e_r;
      energy_total <= energy_sum;
      tension      <= ten_r;
      invalid      <= error_seen;
      force_x      <= (cmd_r == CMD_READ) ? frc[47:0] : '0;
      force_y      <= (cmd_r == CMD_READ) ? frc[95:48] : '0;
      force_z      <= (cmd_r == CMD_READ) ? frc[143:96] : '0;
    end
  end

endmodule
